FILE: hw/rtl/time_value_to_exponent_code_assert.svh
// ----------------------------------------------------------------------------
// Time code encoder assertion macros
// Shared concurrent checks, clocked on i_clk and held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TIME_VALUE_TO_EXPONENT_CODE_ASSERT_SVH
`define TIME_VALUE_TO_EXPONENT_CODE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define TVEC_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define TVEC_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/tvec_pkg.sv
// ----------------------------------------------------------------------------
// Time code encoder package
// Constants, the inter-stage word and the per-stage helper functions.
// ----------------------------------------------------------------------------
package tvec_pkg;

    localparam logic [31:0] TimeMin   = 32'd1;
    localparam logic [31:0] TimeMax   = 32'd3932160000;
    localparam logic [31:0] WinLow    = 32'd1000;
    localparam logic [31:0] WinHigh   = 32'd1875;
    localparam logic [10:0] Step      = 11'd125;
    localparam logic [10:0] StepRound = 11'd124;
    localparam logic [4:0]  ExpBase   = 5'd10;
    localparam int          ManMax    = 8;

    // Normalization stages shift by 16, 8, 4, 2, 1.
    localparam int NormSteps = 5;
    // Clamp stage, normalization stages, code stage.
    localparam int PipeDepth = NormSteps + 2;

    typedef struct packed {
        logic        up;       // halve toward the window, else double
        logic        clamped;
        logic [31:0] val;
        logic [4:0]  expo;
    } t_norm_word;

    // One binary-search step of the normalization: shift by s when the
    // remaining distance to the window is at least s.
    function automatic t_norm_word norm_step(input t_norm_word w, input logic [4:0] s);
        logic [32:0] rnd;
        logic [31:0] hi_lim;
        logic [31:0] lo_lim;
        t_norm_word  r;
        hi_lim = WinHigh << (s - 5'd1);
        lo_lim = (WinLow + ((32'd1 << (s - 5'd1)) - 32'd1)) >> (s - 5'd1);
        rnd    = {1'b0, w.val} + ((33'd1 << s) - 33'd1);
        r      = w;
        if (w.up) begin
            if (w.val > hi_lim) begin
                r.val  = 32'(rnd >> s);
                r.expo = w.expo + s;
            end
        end else begin
            if (w.val < lo_lim) begin
                r.val  = w.val << s;
                r.expo = w.expo - s;
            end
        end
        return r;
    endfunction

    // Mantissa step ceil((w - 1000) / 125) for w in 938..1998, as a count
    // of the step thresholds that w reaches.
    function automatic logic [3:0] mant_step(input logic [10:0] w);
        logic [3:0]  cnt;
        logic [10:0] thr;
        cnt = 4'd0;
        for (int t = 1; t <= ManMax; t++) begin
            thr = 11'(WinLow) - StepRound + 11'(Step * 11'(t));
            if (w >= thr) begin
                cnt = cnt + 4'd1;
            end
        end
        return cnt;
    endfunction

endpackage

FILE: hw/rtl/tvec_clamp.sv
// ----------------------------------------------------------------------------
// Time code encoder input stage
// Clamp the time into range, pick the normalization direction, register.
// ----------------------------------------------------------------------------
module tvec_clamp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  logic [31:0]          i_time_ms,
    output logic                 o_vld,
    output tvec_pkg::t_norm_word o_word
);

    logic                 r_vld;
    tvec_pkg::t_norm_word r_word;
    tvec_pkg::t_norm_word n_word;

    always_comb begin
        n_word.clamped = 1'b0;
        n_word.val     = i_time_ms;
        if (i_time_ms < tvec_pkg::TimeMin) begin
            n_word.val     = tvec_pkg::TimeMin;
            n_word.clamped = 1'b1;
        end else if (i_time_ms > tvec_pkg::TimeMax) begin
            n_word.val     = tvec_pkg::TimeMax;
            n_word.clamped = 1'b1;
        end
        n_word.up   = (n_word.val >= tvec_pkg::WinLow);
        n_word.expo = tvec_pkg::ExpBase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_vld  = r_vld;
    assign o_word = r_word;

endmodule

FILE: hw/rtl/tvec_norm.sv
// ----------------------------------------------------------------------------
// Time code encoder normalization pipeline
// Bring the value into 938..1998, around the 1000..1875 window, one stage per shift size.
// ----------------------------------------------------------------------------
`include "time_value_to_exponent_code_assert.svh"

module tvec_norm (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  tvec_pkg::t_norm_word i_word,
    output logic                 o_vld,
    output tvec_pkg::t_norm_word o_word
);

    logic [tvec_pkg::NormSteps-1:0] r_vld;
    tvec_pkg::t_norm_word           r_word [tvec_pkg::NormSteps];

    for (genvar j = 0; j < tvec_pkg::NormSteps; j++) begin : g_step
        localparam logic [4:0] Shift = 5'(1 << (tvec_pkg::NormSteps - 1 - j));

        tvec_pkg::t_norm_word w_in;
        tvec_pkg::t_norm_word n_word;
        logic                 v_in;

        if (j == 0) begin : g_first
            assign w_in = i_word;
            assign v_in = i_vld;
        end else begin : g_next
            assign w_in = r_word[j-1];
            assign v_in = r_vld[j-1];
        end

        always_comb begin
            n_word = tvec_pkg::norm_step(w_in, Shift);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else begin
                r_vld[j] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_word[j] <= n_word;
        end
    end

    assign o_vld  = r_vld[tvec_pkg::NormSteps-1];
    assign o_word = r_word[tvec_pkg::NormSteps-1];

    // No normalized value, halved or doubled, reaches twice the window floor.
    `TVEC_CHECK(a_norm_top, o_vld, o_word.val < (tvec_pkg::WinLow << 1), "normalized value too high")
    // A halved value lands between half the window floor and the window ceiling.
    `TVEC_CHECK(a_norm_half, o_vld && o_word.up, o_word.val >= (tvec_pkg::WinLow >> 1) && o_word.val <= tvec_pkg::WinHigh, "halved value outside window")
    // A doubled value reaches the window floor.
    `TVEC_CHECK(a_norm_dbl, o_vld && !o_word.up, o_word.val >= tvec_pkg::WinLow, "doubled value below window")
    // Halving only raises the exponent.
    `TVEC_CHECK_NEXT(a_norm_exp, i_vld && i_word.up, r_word[0].expo >= tvec_pkg::ExpBase, "exponent fell while halving")

endmodule

FILE: hw/rtl/tvec_code.sv
// ----------------------------------------------------------------------------
// Time code encoder output stage
// Form the mantissa step and the 8-bit code, register the result word.
// ----------------------------------------------------------------------------
module tvec_code (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  tvec_pkg::t_norm_word i_word,
    output logic                 o_strobe,
    output logic [7:0]           o_time_code,
    output logic                 o_clamped
);

    logic       r_strobe;
    logic [7:0] r_code;
    logic       r_clamped;
    logic [7:0] n_code;
    logic [3:0] mant;

    // A mantissa of 8 carries into the exponent field.
    always_comb begin
        mant   = tvec_pkg::mant_step(i_word.val[10:0]);
        n_code = {i_word.expo, 3'b000} + {4'b0000, mant};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code    <= n_code;
        r_clamped <= i_word.clamped;
    end

    assign o_strobe    = r_strobe;
    assign o_time_code = r_code;
    assign o_clamped   = r_clamped;

endmodule

FILE: hw/rtl/time_value_to_exponent_code.sv
// Path: a word taken at a clock edge goes through the clamp, normalization and
//   code registers to the result ports, where o_strobe marks it.
// Throughput: one word per cycle through seven register stages (clamp, five
//   normalization shifts of 16/8/4/2/1, code); busy is low whenever out of reset.
// Reset: synchronous on i_rst_n, drops all words in flight; busy is high in reset.
// ----------------------------------------------------------------------------
// Time code encoder
// Encodes a millisecond time into the 8-bit code 8*b + a, where the code
// stands for (1000 + 125*a) * 2^(b-10) ms, the smallest such time not below
// the input. Inputs outside 1..3932160000 are clamped and flagged.
// ----------------------------------------------------------------------------
`include "time_value_to_exponent_code_assert.svh"

module time_value_to_exponent_code (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_time_ms,
    output logic        o_strobe,
    output logic [7:0]  o_time_code,
    output logic        o_clamped
);

    logic                 clamp_vld;
    tvec_pkg::t_norm_word clamp_word;
    logic                 norm_vld;
    tvec_pkg::t_norm_word norm_word;
    logic                 take;

    // The pipeline never stalls: hold off words only while in reset.
    assign busy = !i_rst_n;
    assign take = start && !busy;

    // Stage 1: clamp into range, choose halving or doubling.
    tvec_clamp u_clamp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (take),
        .i_time_ms (i_time_ms),
        .o_vld     (clamp_vld),
        .o_word    (clamp_word)
    );

    // Stages 2 to 6: binary search of the shift count, one shift size a stage.
    // Halving rounds up, so the steps compose into one rounded-up division.
    tvec_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (clamp_vld),
        .i_word  (clamp_word),
        .o_vld   (norm_vld),
        .o_word  (norm_word)
    );

    // Stage 7: mantissa step and code assembly.
    tvec_code u_code (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (norm_vld),
        .i_word      (norm_word),
        .o_strobe    (o_strobe),
        .o_time_code (o_time_code),
        .o_clamped   (o_clamped)
    );

    // Every result traces back to a word taken a fixed pipeline depth earlier.
    `TVEC_CHECK(a_top_lat, o_strobe, $past(take, tvec_pkg::PipeDepth), "result without a word")
    // Every result is a nonzero code, even for the smallest legal input.
    `TVEC_CHECK(a_top_nz, o_strobe, o_time_code != 8'd0, "zero time code")
    // A zero input is raised to one millisecond, which is code one.
    `TVEC_CHECK(a_top_zero, o_strobe && $past(i_time_ms == 32'd0, tvec_pkg::PipeDepth), o_clamped && o_time_code == 8'd1, "zero input misencoded")

endmodule
